// ===== src/sit_pkg.sv =====
// shared types, constants and saturating arithmetic for the segment intersection test
`timescale 1ns / 1ps

package sit_pkg;

   localparam int XW = 64;
   localparam int HW = XW / 2;
   localparam int TOL_W = 16;

   typedef logic signed [XW-1:0] word_type;
   typedef logic [XW-1:0] uword_type;

   localparam word_type SAT_LIM = {1'b0, {(XW-1){1'b1}}};
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd13;

   function automatic uword_type mag(input word_type a);
      uword_type r;
      r = a[XW-1] ? uword_type'(-a) : uword_type'(a);
      return r;
   endfunction

   // sum clamped to the symmetric range
   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [XW:0] s;
      s = (XW+1)'(a) + (XW+1)'(b);
      if (s > (XW+1)'(SAT_LIM)) begin
         return SAT_LIM;
      end else if (s < -((XW+1)'(SAT_LIM))) begin
         return -SAT_LIM;
      end
      return s[XW-1:0];
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [XW:0] s;
      s = (XW+1)'(a) - (XW+1)'(b);
      if (s > (XW+1)'(SAT_LIM)) begin
         return SAT_LIM;
      end else if (s < -((XW+1)'(SAT_LIM))) begin
         return -SAT_LIM;
      end
      return s[XW-1:0];
   endfunction

endpackage

// ===== src/segment_intersection_test.sv =====
// top level of the segment intersection test pipeline
//
// Usage: one transaction on the req_ channel carries two segments (eight
// signed fixed-point coordinates); one transaction on the rsp_ channel returns
// the hit flag on rsp_tuser and the crossing point on rsp_tdata, zero on a
// miss. Results come back in request order, one per request.
// Throughput is one request per cycle unless rsp_tready stalls the pipeline.
// At Q16.16 (the default parameters) the two slope divisions and the crossing
// division are each a pipelined divider that settles one quotient bit a stage.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready falls with it; nothing is dropped.
// The vertical tolerance sits in a register written through csr_wr_en and
// csr_wr_data; reset sets it to 13 (0.0002) and empties the pipeline.
// Reset is synchronous and active high.
`timescale 1ns / 1ps

module segment_intersection_test #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [((8*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // cross_x, cross_y
   output logic [((2*COORD_BITS+7)/8)*8-1:0]        rsp_tdata,
   // hit
   output logic [0:0]                               rsp_tuser,
   input  logic                                     csr_wr_en,
   input  logic [sit_pkg::TOL_W-1:0]                csr_wr_data
);

   localparam int XW = sit_pkg::XW;
   localparam int CW = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
   } seg_type;

   typedef struct packed {
      seg_type q;
      logic    vert;
      logic    both;
   } qside_type;

   typedef struct packed {
      qside_type         qs;
      sit_pkg::word_type m;
   } qmul_type;

   typedef struct packed {
      seg_type           p;
      sit_pkg::word_type m;
   } pmul_type;

   typedef struct packed {
      seg_type           p;
      seg_type           q;
      logic              vert;
      logic              both;
      logic              par;
      sit_pkg::word_type mc;
      sit_pkg::word_type bc;
   } dside_type;

   typedef struct packed {
      seg_type           p;
      seg_type           q;
      logic              vert;
      logic              both;
      logic              par;
      sit_pkg::word_type bc;
      sit_pkg::word_type ix;
   } mside_type;

   function automatic logic is_vert(input seg_type s, input logic [sit_pkg::TOL_W-1:0] tol);
      logic signed [DW-1:0] dx;
      logic [DW-1:0]        dm;
      dx = DW'(s.sx) - DW'(s.ex);
      dm = dx[DW-1] ? DW'(-dx) : DW'(dx);
      return (dx == '0) || (dm < DW'(tol));
   endfunction

   function automatic logic in_box(input seg_type s, input sit_pkg::word_type x,
                                   input sit_pkg::word_type y);
      logic signed [CW-1:0] lx, hx, ly, hy;
      lx = (s.sx < s.ex) ? s.sx : s.ex;
      hx = (s.sx < s.ex) ? s.ex : s.sx;
      ly = (s.sy < s.ey) ? s.sy : s.ey;
      hy = (s.sy < s.ey) ? s.ey : s.sy;
      return (x >= XW'(lx)) && (x <= XW'(hx)) && (y >= XW'(ly)) && (y <= XW'(hy));
   endfunction

   logic                        ce;
   logic [sit_pkg::TOL_W-1:0]   tol_ff;

   // input register
   logic                        t0_vld_ff;
   seg_type                     t0_s0_ff, t0_s1_ff;
   seg_type                     req_s0, req_s1;

   // vertical test and role swap
   logic                        t1_vld_ff;
   seg_type                     t1_p_ff, t1_q_ff;
   logic                        t1_vert_ff, t1_both_ff;
   logic                        v1, v2;

   // slope dividers
   sit_pkg::word_type           dq_num, dq_den, dp_num, dp_den;
   qside_type                   dq_side_in, dq_side;
   seg_type                     dp_side;
   logic                        dq_vld, dp_vld;
   sit_pkg::word_type           m2, m1;

   // intercept multipliers
   qmul_type                    mq_side_in, mq_side;
   pmul_type                    mp_side_in, mp_side;
   logic                        mq_vld, mp_vld;
   sit_pkg::word_type           prod_q, prod_p;

   logic                        tb_vld_ff;
   qside_type                   tb_qs_ff;
   seg_type                     tb_p_ff;
   sit_pkg::word_type           tb_m1_ff, tb_m2_ff, tb_b1_ff, tb_b2_ff;

   logic                        tc_vld_ff;
   dside_type                   tc_side_ff;
   sit_pkg::word_type           tc_num_ff, tc_dm_ff;

   // crossing divider and multiplier
   dside_type                   dx_side;
   logic                        dx_vld;
   sit_pkg::word_type           dx_quo;
   mside_type                   mx_side_in, mx_side;
   logic                        mx_vld;
   sit_pkg::word_type           mx_prod;

   logic                        td_vld_ff;
   mside_type                   td_side_ff;
   sit_pkg::word_type           td_iy_ff;

   // output register
   logic                        rsp_vld_ff;
   logic                        rsp_hit_ff;
   logic [CW-1:0]               rsp_x_ff, rsp_y_ff;
   logic                        hit;

   assign ce         = !rsp_vld_ff || rsp_tready;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= sit_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   assign req_s0 = {req_tdata[0*CW +: CW], req_tdata[1*CW +: CW],
                    req_tdata[2*CW +: CW], req_tdata[3*CW +: CW]};
   assign req_s1 = {req_tdata[4*CW +: CW], req_tdata[5*CW +: CW],
                    req_tdata[6*CW +: CW], req_tdata[7*CW +: CW]};

   assign v1 = is_vert(t0_s0_ff, tol_ff);
   assign v2 = is_vert(t0_s1_ff, tol_ff);

   assign dq_num = XW'(t1_q_ff.sy) - XW'(t1_q_ff.ey);
   assign dq_den = XW'(t1_q_ff.sx) - XW'(t1_q_ff.ex);
   assign dp_num = XW'(t1_p_ff.sy) - XW'(t1_p_ff.ey);
   assign dp_den = XW'(t1_p_ff.sx) - XW'(t1_p_ff.ex);
   assign dq_side_in = '{q: t1_q_ff, vert: t1_vert_ff, both: t1_both_ff};

   sit_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(qside_type))) u_div_q (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(t1_vld_ff), .in_num(dq_num), .in_den(dq_den), .in_side(dq_side_in),
      .out_valid(dq_vld), .out_quo(m2), .out_side(dq_side)
   );

   sit_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(seg_type))) u_div_p (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(t1_vld_ff), .in_num(dp_num), .in_den(dp_den), .in_side(t1_p_ff),
      .out_valid(dp_vld), .out_quo(m1), .out_side(dp_side)
   );

   assign mq_side_in = '{qs: dq_side, m: m2};
   assign mp_side_in = '{p: dp_side, m: m1};

   sit_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(qmul_type))) u_mul_q (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(dq_vld), .in_a(m2), .in_b(XW'(dq_side.q.sx)), .in_side(mq_side_in),
      .out_valid(mq_vld), .out_prod(prod_q), .out_side(mq_side)
   );

   sit_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(pmul_type))) u_mul_p (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(dp_vld), .in_a(m1), .in_b(XW'(dp_side.sx)), .in_side(mp_side_in),
      .out_valid(mp_vld), .out_prod(prod_p), .out_side(mp_side)
   );

   // vertical case takes x from the vertical segment, otherwise the solved x
   assign mx_side_in = '{p: dx_side.p, q: dx_side.q, vert: dx_side.vert,
                         both: dx_side.both, par: dx_side.par, bc: dx_side.bc,
                         ix: dx_side.vert ? XW'(dx_side.p.sx) : dx_quo};

   sit_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(dside_type))) u_div_x (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(tc_vld_ff), .in_num(tc_num_ff), .in_den(tc_dm_ff), .in_side(tc_side_ff),
      .out_valid(dx_vld), .out_quo(dx_quo), .out_side(dx_side)
   );

   sit_mul #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(mside_type))) u_mul_y (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(dx_vld), .in_a(dx_side.mc), .in_b(mx_side_in.ix), .in_side(mx_side_in),
      .out_valid(mx_vld), .out_prod(mx_prod), .out_side(mx_side)
   );

   assign hit = !td_side_ff.both && !td_side_ff.par
                && in_box(td_side_ff.p, td_side_ff.ix, td_iy_ff)
                && in_box(td_side_ff.q, td_side_ff.ix, td_iy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff  <= 1'b0;
         t1_vld_ff  <= 1'b0;
         tb_vld_ff  <= 1'b0;
         tc_vld_ff  <= 1'b0;
         td_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (ce) begin
         t0_vld_ff  <= req_tvalid;
         t1_vld_ff  <= t0_vld_ff;
         tb_vld_ff  <= mq_vld && mp_vld;
         tc_vld_ff  <= tb_vld_ff;
         td_vld_ff  <= mx_vld;
         rsp_vld_ff <= td_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         t0_s0_ff <= req_s0;
         t0_s1_ff <= req_s1;

         // second segment vertical, alone or with the first: roles swap
         t1_p_ff    <= v2 ? t0_s1_ff : t0_s0_ff;
         t1_q_ff    <= v2 ? t0_s0_ff : t0_s1_ff;
         t1_vert_ff <= v1 || v2;
         t1_both_ff <= v1 && v2;

         tb_qs_ff <= mq_side.qs;
         tb_p_ff  <= mp_side.p;
         tb_m2_ff <= mq_side.m;
         tb_m1_ff <= mp_side.m;
         tb_b2_ff <= sit_pkg::sat_sub(XW'(mq_side.qs.q.sy), prod_q);
         tb_b1_ff <= sit_pkg::sat_sub(XW'(mp_side.p.sy), prod_p);

         tc_side_ff <= '{p: tb_p_ff, q: tb_qs_ff.q, vert: tb_qs_ff.vert,
                         both: tb_qs_ff.both,
                         par: !tb_qs_ff.vert && (tb_m2_ff == tb_m1_ff),
                         mc: tb_qs_ff.vert ? tb_m2_ff : tb_m1_ff,
                         bc: tb_qs_ff.vert ? tb_b2_ff : tb_b1_ff};
         tc_num_ff  <= sit_pkg::sat_sub(tb_b1_ff, tb_b2_ff);
         tc_dm_ff   <= sit_pkg::sat_sub(tb_m2_ff, tb_m1_ff);

         td_side_ff <= mx_side;
         td_iy_ff   <= sit_pkg::sat_add(mx_prod, mx_side.bc);

         rsp_hit_ff <= hit;
         rsp_x_ff   <= hit ? td_side_ff.ix[CW-1:0] : '0;
         rsp_y_ff   <= hit ? td_iy_ff[CW-1:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = OUT_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_hit_ff;

endmodule

// ===== src/sit_div.sv =====
// pipelined restoring divider: trunc(num * 2^frac / den), saturated, one quotient bit per stage
`timescale 1ns / 1ps

module sit_div #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ce,
   input  logic                 in_valid,
   input  sit_pkg::word_type    in_num,
   input  sit_pkg::word_type    in_den,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output sit_pkg::word_type    out_quo,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int XW = sit_pkg::XW;
   localparam int NB = XW + FRAC_BITS;

   logic [NB:0]        vld_ff;
   logic [XW-1:0]      rem_ff  [NB+1];
   logic [NB-1:0]      dvd_ff  [NB+1];
   logic [NB-1:0]      quo_ff  [NB+1];
   logic [XW-1:0]      den_ff  [NB+1];
   logic               neg_ff  [NB+1];
   logic [SIDE_W-1:0]  side_ff [NB+1];

   logic [XW:0]        trial [NB];
   logic [XW:0]        diff  [NB];
   logic               fits  [NB];

   logic               out_vld_ff;
   sit_pkg::word_type  out_quo_ff;
   logic [SIDE_W-1:0]  out_side_ff;

   logic               over;
   sit_pkg::word_type  mq;

   always_comb begin
      for (int k = 0; k < NB; k++) begin
         trial[k] = {rem_ff[k], dvd_ff[k][NB-1]};
         diff[k]  = trial[k] - {1'b0, den_ff[k]};
         fits[k]  = trial[k] >= {1'b0, den_ff[k]};
      end
   end

   // quotient at or above 2^63 saturates
   assign over = |quo_ff[NB][NB-1:XW-1];
   assign mq   = over ? sit_pkg::SAT_LIM : {1'b0, quo_ff[NB][XW-2:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (ce) begin
         vld_ff     <= {vld_ff[NB-1:0], in_valid};
         out_vld_ff <= vld_ff[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rem_ff[0]  <= '0;
         dvd_ff[0]  <= {sit_pkg::mag(in_num), {FRAC_BITS{1'b0}}};
         quo_ff[0]  <= '0;
         den_ff[0]  <= sit_pkg::mag(in_den);
         neg_ff[0]  <= in_num[XW-1] ^ in_den[XW-1];
         side_ff[0] <= in_side;
         for (int k = 0; k < NB; k++) begin
            rem_ff[k+1]  <= fits[k] ? diff[k][XW-1:0] : trial[k][XW-1:0];
            dvd_ff[k+1]  <= {dvd_ff[k][NB-2:0], 1'b0};
            quo_ff[k+1]  <= {quo_ff[k][NB-2:0], fits[k]};
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
         out_quo_ff  <= neg_ff[NB] ? -mq : mq;
         out_side_ff <= side_ff[NB];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_quo   = out_quo_ff;
   assign out_side  = out_side_ff;

endmodule

// ===== src/sit_mul.sv =====
// pipelined fixed-point multiplier: trunc(a * b / 2^frac), saturated, built from 32x32 products
`timescale 1ns / 1ps

module sit_mul #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ce,
   input  logic                 in_valid,
   input  sit_pkg::word_type    in_a,
   input  sit_pkg::word_type    in_b,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output sit_pkg::word_type    out_prod,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int XW = sit_pkg::XW;
   localparam int HW = sit_pkg::HW;

   logic [4:0]         vld_ff;

   logic [XW-1:0]      ua_ff, ub_ff;
   logic               neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [SIDE_W-1:0]  side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;

   logic [XW-1:0]      p0_ff, p1_ff, p2_ff, p3_ff;
   logic [XW-1:0]      p0b_ff, p3b_ff;
   logic [XW:0]        mid_ff;
   logic [2*XW-1:0]    prod_ff;
   sit_pkg::word_type  res_ff;

   logic               sat;
   sit_pkg::word_type  mq;

   assign sat = |prod_ff[2*XW-1:XW-1+FRAC_BITS];
   assign mq  = sat ? sit_pkg::SAT_LIM : {1'b0, prod_ff[XW-2+FRAC_BITS:FRAC_BITS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         // magnitudes and sign
         ua_ff    <= sit_pkg::mag(in_a);
         ub_ff    <= sit_pkg::mag(in_b);
         neg1_ff  <= in_a[XW-1] ^ in_b[XW-1];
         side1_ff <= in_side;
         // partial products
         p0_ff    <= ua_ff[HW-1:0]  * ub_ff[HW-1:0];
         p1_ff    <= ua_ff[HW-1:0]  * ub_ff[XW-1:HW];
         p2_ff    <= ua_ff[XW-1:HW] * ub_ff[HW-1:0];
         p3_ff    <= ua_ff[XW-1:HW] * ub_ff[XW-1:HW];
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
         // cross terms
         mid_ff   <= {1'b0, p1_ff} + {1'b0, p2_ff};
         p0b_ff   <= p0_ff;
         p3b_ff   <= p3_ff;
         neg3_ff  <= neg2_ff;
         side3_ff <= side2_ff;
         // full product
         prod_ff  <= {p3b_ff, p0b_ff} + ((2*XW)'(mid_ff) << HW);
         neg4_ff  <= neg3_ff;
         side4_ff <= side3_ff;
         // scale and saturate
         res_ff   <= neg4_ff ? -mq : mq;
         side5_ff <= side4_ff;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_prod  = res_ff;
   assign out_side  = side5_ff;

endmodule

// ===== tb/tb_segment_intersection_test.sv =====
// self-checking testbench for the segment intersection test block
`timescale 1ns / 1ps

module tb_segment_intersection_test;

   localparam int CB = 32;
   localparam int FB = 16;
   localparam int LATENCY = 2 * (64 + FB) + 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1500;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct packed {
      coord_type ey2, ex2, sy2, sx2, ey1, ex1, sy1, sx1;
   } seg_pair_type;
   typedef struct packed {
      logic hit;
      coord_type cy;
      coord_type cx;
   } crossing_type;

   // directed row: segment pair, optional hand-typed expectation
   typedef struct {
      seg_pair_type pair;
      bit typed;
      crossing_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [8*CB-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [2*CB-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [sit_pkg::TOL_W-1:0] csr_wr_data = '0;

   segment_intersection_test #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   logic [sit_pkg::TOL_W-1:0] model_tol;
   crossing_type pending_crossings[$];
   int mismatches = 0;
   int hits_seen = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit rsp_stalls_on = 1'b1;
   bit timed_out = 1'b0;

   // ---------------- predictor ----------------
   function automatic sit_pkg::word_type sat_of(sit_pkg::uword_type m, bit neg);
      sit_pkg::word_type v;
      v = (m > sit_pkg::uword_type'(sit_pkg::SAT_LIM)) ? sit_pkg::SAT_LIM
                                                      : sit_pkg::word_type'(m);
      return neg ? -v : v;
   endfunction

   function automatic sit_pkg::word_type fixed_mul(sit_pkg::word_type a,
                                                   sit_pkg::word_type b);
      logic [127:0] p;
      sit_pkg::uword_type s;
      p = sit_pkg::mag(a) * sit_pkg::mag(b);
      if (p[127:64+FB] != '0) s = sit_pkg::uword_type'(sit_pkg::SAT_LIM);
      else s = p[63+FB:FB];
      return sat_of(s, (a < 0) != (b < 0));
   endfunction

   function automatic sit_pkg::word_type fixed_div(sit_pkg::word_type a,
                                                   sit_pkg::word_type b);
      logic [127:0] n, q;
      sit_pkg::uword_type s;
      if (b == 0) return sat_of(sit_pkg::uword_type'(sit_pkg::SAT_LIM), a < 0);
      n = {64'd0, sit_pkg::mag(a)} << FB;
      q = n / {64'd0, sit_pkg::mag(b)};
      s = (q > {64'd0, sit_pkg::uword_type'(sit_pkg::SAT_LIM)})
          ? sit_pkg::uword_type'(sit_pkg::SAT_LIM) : q[63:0];
      return sat_of(s, (a < 0) != (b < 0));
   endfunction

   function automatic bit near_vertical(sit_pkg::word_type xa, sit_pkg::word_type xb);
      sit_pkg::word_type dx;
      dx = xa - xb;
      return dx == 0 || sit_pkg::mag(dx) < sit_pkg::uword_type'(model_tol);
   endfunction

   function automatic bit inside_box(sit_pkg::word_type s[4], sit_pkg::word_type x,
                                     sit_pkg::word_type y);
      sit_pkg::word_type lx, hx, ly, hy;
      lx = s[0] < s[2] ? s[0] : s[2];
      hx = s[0] < s[2] ? s[2] : s[0];
      ly = s[1] < s[3] ? s[1] : s[3];
      hy = s[1] < s[3] ? s[3] : s[1];
      return x >= lx && x <= hx && y >= ly && y <= hy;
   endfunction

   function automatic crossing_type predict_crossing(seg_pair_type sp);
      sit_pkg::word_type a[4], b[4], p[4], q[4];
      sit_pkg::word_type m1, b1, m2, b2, ix, iy, dm;
      bit v1, v2;
      crossing_type r;
      r = '0;
      a = '{sit_pkg::word_type'(sp.sx1), sit_pkg::word_type'(sp.sy1),
            sit_pkg::word_type'(sp.ex1), sit_pkg::word_type'(sp.ey1)};
      b = '{sit_pkg::word_type'(sp.sx2), sit_pkg::word_type'(sp.sy2),
            sit_pkg::word_type'(sp.ex2), sit_pkg::word_type'(sp.ey2)};
      v1 = near_vertical(a[0], a[2]);
      v2 = near_vertical(b[0], b[2]);
      if (v1 && v2) return r;
      if (v2) begin
         p = b;
         q = a;
      end else begin
         p = a;
         q = b;
      end
      m2 = fixed_div(q[1] - q[3], q[0] - q[2]);
      b2 = sit_pkg::sat_sub(q[1], fixed_mul(m2, q[0]));
      if (v1 || v2) begin
         ix = p[0];
         iy = sit_pkg::sat_add(fixed_mul(m2, ix), b2);
      end else begin
         m1 = fixed_div(p[1] - p[3], p[0] - p[2]);
         b1 = sit_pkg::sat_sub(p[1], fixed_mul(m1, p[0]));
         dm = sit_pkg::sat_sub(m2, m1);
         if (dm == 0) return r;
         ix = fixed_div(sit_pkg::sat_sub(b1, b2), dm);
         iy = sit_pkg::sat_add(fixed_mul(m1, ix), b1);
      end
      if (!inside_box(p, ix, iy) || !inside_box(q, ix, iy)) return r;
      r.hit = 1'b1;
      r.cx = ix[CB-1:0];
      r.cy = iy[CB-1:0];
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0]) hits_seen++;
         if (pending_crossings.size() == 0) begin
            report_mismatch("unexpected result", {31'd0, rsp_tuser, rsp_tdata[31:0]}, '0);
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_tuser[0] !== want.hit)
               report_mismatch("hit", 64'(rsp_tuser), 64'(want.hit));
            if (rsp_tdata[CB-1:0] !== want.cx)
               report_mismatch("cross_x", 64'(rsp_tdata[CB-1:0]), 64'(want.cx));
            if (rsp_tdata[2*CB-1:CB] !== want.cy)
               report_mismatch("cross_y", 64'(rsp_tdata[2*CB-1:CB]), 64'(want.cy));
         end
      end
   end

   // watchdog on cycles with no transaction on either side and no tolerance write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired with %0d results outstanding", pending_crossings.size());
         $display("tb_segment_intersection_test NOT OK");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 9);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 20);
         end
         repeat (n) @(negedge clock);
      end
   end

   // ---------------- stimulus ----------------
   // tvalid stays high after the transaction so that pairs can follow back to back
   task automatic send_pair(seg_pair_type sp, bit gaps, bit typed = 0,
                            crossing_type want = '0);
      int n;
      if (gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 9);
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_crossings.push_back(typed ? want : predict_crossing(sp));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_crossings.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [sit_pkg::TOL_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_tol = v;
   endtask

   function automatic coord_type rand_coord(int style);
      unique case (style)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
         default: return coord_type'($signed($urandom_range(0, 400)) - 200) <<< FB;
      endcase
   endfunction

   // build a pair: mostly one that crosses near a random centre point, with varied direction, else random coordinates
   function automatic seg_pair_type rand_pair();
      seg_pair_type sp;
      coord_type cx, cy, dx, dy;
      int style;
      style = $urandom_range(0, 9);
      if (style == 0) begin
         sp = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (style < 3) begin
         sp = {rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
               rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(2)};
      end else begin
         cx = rand_coord(1);
         cy = rand_coord(1);
         dx = coord_type'($signed($urandom_range(0, 1 << (FB + 4))) - (1 << (FB + 3)));
         dy = coord_type'($signed($urandom_range(0, 1 << (FB + 4))) - (1 << (FB + 3)));
         if ($urandom_range(0, 5) == 0) dx = coord_type'($urandom_range(0, 20));
         sp.sx1 = cx - dx; sp.sy1 = cy - dy; sp.ex1 = cx + dx; sp.ey1 = cy + dy;
         dx = coord_type'($signed($urandom_range(0, 1 << (FB + 4))) - (1 << (FB + 3)));
         dy = coord_type'($signed($urandom_range(0, 1 << (FB + 4))) - (1 << (FB + 3)));
         if ($urandom_range(0, 5) == 0) dy = -dy;
         sp.sx2 = cx + dx; sp.sy2 = cy - dy; sp.ex2 = cx - dx; sp.ey2 = cy + dy;
         if ($urandom_range(0, 7) == 0) sp.sx2 = sp.ex2 + coord_type'($urandom_range(0, 20));
      end
      return sp;
   endfunction

   localparam coord_type ONE = 1 <<< FB;
   localparam coord_type MAXC = {1'b0, {(CB-1){1'b1}}};
   localparam coord_type MINC = {1'b1, {(CB-1){1'b0}}};

   directed_row_type directed[$];

   function automatic seg_pair_type mk(coord_type a, coord_type b, coord_type c, coord_type d,
                                       coord_type e, coord_type f, coord_type g, coord_type h);
      seg_pair_type sp;
      sp.sx1 = a; sp.sy1 = b; sp.ex1 = c; sp.ey1 = d;
      sp.sx2 = e; sp.sy2 = f; sp.ex2 = g; sp.ey2 = h;
      return sp;
   endfunction

   initial begin
      int tol_pick;
      model_tol = sit_pkg::TOL_RESET;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // crossing diagonals meet at the origin
      directed.push_back('{mk(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE), 1, '{1'b1, 0, 0}});
      // both vertical
      directed.push_back('{mk(0, 0, 0, ONE, ONE, 0, ONE, ONE), 1, '0});
      // parallel horizontals
      directed.push_back('{mk(0, 0, ONE, 0, 0, ONE, ONE, ONE), 1, '0});
      // same line
      directed.push_back('{mk(0, 0, ONE, ONE, 0, 0, ONE, ONE), 1, '0});
      // first vertical at x = 0 across a horizontal at y = 0
      directed.push_back('{mk(0, -ONE, 0, ONE, -ONE, 0, ONE, 0), 1, '{1'b1, 0, 0}});
      // second vertical only, swap of roles
      directed.push_back('{mk(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE), 1, '{1'b1, 0, 0}});
      // near vertical inside tolerance
      directed.push_back('{mk(5, -ONE, 0, ONE, -ONE, 0, ONE, 0), 0, '0});
      // touching at an endpoint, inclusive boxes
      directed.push_back('{mk(0, 0, ONE, ONE, ONE, ONE, 2 * ONE, 0), 0, '0});
      // disjoint boxes
      directed.push_back('{mk(0, 0, ONE, ONE, 4 * ONE, 0, 5 * ONE, ONE), 1, '0});
      // extremes, saturating intermediates
      directed.push_back('{mk(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC), 0, '0});
      directed.push_back('{mk(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC), 0, '0});
      directed.push_back('{mk(MINC, 0, MAXC, 1, MINC, 1, MAXC, 0), 0, '0});
      directed.push_back('{mk(MINC, MINC, MINC + 1, MAXC, 0, 0, 1, 1), 0, '0});
      directed.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1), 1, '0});
      directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
      directed.push_back('{mk(MAXC, 0, MAXC - 1, ONE, MAXC - 1, ONE, MAXC, 0), 0, '0});

      foreach (directed[i]) send_pair(directed[i].pair, 0, directed[i].typed, directed[i].want);
      drain_results();

      // zero tolerance: only an exact zero extent is vertical
      write_tolerance('0);
      send_pair(mk(1, -ONE, 0, ONE, -ONE, 0, ONE, 0), 0);
      send_pair(mk(0, -ONE, 0, ONE, -ONE, 0, ONE, 0), 0, 1, '{1'b1, 0, 0});
      drain_results();
      write_tolerance('1);
      send_pair(mk(-ONE, -ONE, -ONE + 16'hFFFE, ONE, -2 * ONE, 0, 2 * ONE, 0), 0);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 300 == 0 && i != 0) begin
            drain_results();
            tol_pick = $urandom_range(0, 3);
            write_tolerance(tol_pick == 0 ? 16'd0 : tol_pick == 1 ? 16'hFFFF :
                            tol_pick == 2 ? sit_pkg::TOL_RESET : 16'($urandom));
         end
         if (i >= RANDOM_ITEMS - 150) rsp_stalls_on = 1'b0;
         send_pair(rand_pair(), i < RANDOM_ITEMS - 150);
      end
      drain_results();

      $display("covered %0d results, %0d hits, tolerance from 0 to 65535", results_seen, hits_seen);
      if (mismatches == 0) begin
         $display("tb_segment_intersection_test OK");
      end else begin
         $display("tb_segment_intersection_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sit_pkg.sv
src/sit_div.sv
src/sit_mul.sv
src/segment_intersection_test.sv
tb/tb_segment_intersection_test.sv
